[rtl/mwu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwu_pkg
// Shared types, constants and helpers for the momentum weight update engine.
// ----------------------------------------------------------------------------
package mwu_pkg;

  localparam int unsigned SLOT_COUNT = 1024;
  localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);

  localparam logic [15:0] MF_RESET = 16'd58982;
  localparam logic [15:0] LR_RESET = 16'd655;
  localparam logic [16:0] Q_ONE    = 17'h1_0000;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [0:0] {
    CMD_CLEAR  = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_MOMENTUM = 2'd0,
    CFG_RATE     = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    cmd_e               command;
    logic [SLOT_W-1:0]  slot_index;
    logic signed [31:0] weight_in;
    logic signed [31:0] gradient_in;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] weight_out;
    logic signed [31:0] velocity_out;
  } out_word_t;

  // word leaving the velocity stages
  typedef struct packed {
    cmd_e               command;
    logic signed [31:0] weight;
    logic signed [31:0] velocity;
  } vel_word_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } slot_tag_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    logic [31:0]       data;
  } mem_wr_t;

  function automatic logic signed [31:0] sat_s32(input logic signed [34:0] x);
    logic signed [31:0] r;
    if (x[34:31] == {4{x[34]}}) begin
      r = x[31:0];
    end else if (x[34]) begin
      r = S32_MIN;
    end else begin
      r = S32_MAX;
    end
    return r;
  endfunction

endpackage

[rtl/mwu_vel_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwu_vel_mem
// Per-slot velocity store with registered read and a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module mwu_vel_mem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [mwu_pkg::SLOT_W-1:0] rd_addr_i,
  input  mwu_pkg::mem_wr_t          wr_i,
  output logic [31:0]               rd_data_o,
  output logic                      busy_o
);

  logic [31:0]               mem [mwu_pkg::SLOT_COUNT];
  logic [31:0]               rd_data_q;
  logic [mwu_pkg::SLOT_W-1:0] clr_cnt_q;
  logic                      clr_busy_q;

  // zeroing sweep, one entry a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == mwu_pkg::SLOT_W'(mwu_pkg::SLOT_COUNT - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_busy_q;

endmodule

[rtl/mwu_vel_calc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwu_vel_calc
// Velocity stages: operand capture and products, then sum and saturate (zero on a clear), write back.
// ----------------------------------------------------------------------------
module mwu_vel_calc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                accept_i,
  input  mwu_pkg::in_word_t   in_word_i,
  input  logic [31:0]         rd_data_i,
  input  logic [15:0]         beta_i,
  output mwu_pkg::slot_tag_t  s1_tag_o,
  output mwu_pkg::mem_wr_t    mem_wr_o,
  output logic                s3_valid_o,
  output mwu_pkg::vel_word_t  s3_word_o
);

  logic                       s1_valid_q;
  mwu_pkg::in_word_t          s1_q;
  logic                       s2_valid_q;
  mwu_pkg::cmd_e              s2_cmd_q;
  logic [mwu_pkg::SLOT_W-1:0] s2_slot_q;
  logic signed [31:0]         s2_w_q;
  logic signed [48:0]         s2_pb_q;
  logic signed [49:0]         s2_pg_q;
  logic                       s3_valid_q;
  mwu_pkg::vel_word_t         s3_q;
  logic [mwu_pkg::SLOT_W-1:0] s3_slot_q;

  logic signed [31:0] v_old;
  logic [16:0]        gain;
  logic signed [48:0] pb_d;
  logic signed [49:0] pg_d;
  logic signed [34:0] v_sum;
  logic signed [31:0] v_new;

  // the word one stage ahead wrote its slot at the edge this read was taken
  always_comb begin
    if (s3_valid_q && (s3_slot_q == s1_q.slot_index)) begin
      v_old = s3_q.velocity;
    end else begin
      v_old = $signed(rd_data_i);
    end
    gain = mwu_pkg::Q_ONE - {1'b0, beta_i};
    pb_d = $signed({1'b0, beta_i}) * v_old;
    pg_d = $signed({1'b0, gain}) * s1_q.gradient_in;
  end

  always_comb begin
    v_sum = $signed({{2{s2_pb_q[48]}}, s2_pb_q[48:16]})
          + $signed({s2_pg_q[49], s2_pg_q[49:16]});
    if (s2_cmd_q == mwu_pkg::CMD_UPDATE) begin
      v_new = mwu_pkg::sat_s32(v_sum);
    end else begin
      v_new = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= accept_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (accept_i) begin
        s1_q <= in_word_i;
      end
      s2_cmd_q  <= s1_q.command;
      s2_slot_q <= s1_q.slot_index;
      s2_w_q    <= s1_q.weight_in;
      s2_pb_q   <= pb_d;
      s2_pg_q   <= pg_d;
      s3_q      <= '{command: s2_cmd_q, weight: s2_w_q, velocity: v_new};
      s3_slot_q <= s2_slot_q;
    end
  end

  assign s1_tag_o   = '{valid: s1_valid_q, slot: s1_q.slot_index};
  assign mem_wr_o   = '{we: adv_i && s2_valid_q, addr: s2_slot_q, data: v_new};
  assign s3_valid_o = s3_valid_q;
  assign s3_word_o  = s3_q;

endmodule

[rtl/mwu_wgt_calc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwu_wgt_calc
// Weight stages: step product, then subtract and saturate (weight kept on a clear) into the output register.
// ----------------------------------------------------------------------------
module mwu_wgt_calc (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s3_valid_i,
  input  mwu_pkg::vel_word_t s3_word_i,
  input  logic [15:0]        alpha_i,
  input  logic               out_ready_i,
  output logic               adv_o,
  output logic               out_valid_o,
  output mwu_pkg::out_word_t out_word_o
);

  logic               s4_valid_q;
  mwu_pkg::vel_word_t s4_q;
  logic signed [48:0] s4_pa_q;
  logic               out_valid_q;
  mwu_pkg::out_word_t out_q;

  logic               adv;
  logic               out_en;
  logic signed [48:0] pa_d;
  logic signed [34:0] w_diff;
  logic signed [31:0] w_new;

  // an empty last stage lets the pipe close up behind a held result
  assign out_en = out_ready_i || !out_valid_q;
  assign adv    = out_en || !s4_valid_q;

  always_comb begin
    pa_d   = $signed({1'b0, alpha_i}) * s3_word_i.velocity;
    w_diff = $signed({{3{s4_q.weight[31]}}, s4_q.weight})
           - $signed({{2{s4_pa_q[48]}}, s4_pa_q[48:16]});
    if (s4_q.command == mwu_pkg::CMD_UPDATE) begin
      w_new = mwu_pkg::sat_s32(w_diff);
    end else begin
      w_new = s4_q.weight;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        s4_valid_q <= s3_valid_i;
      end
      if (out_en) begin
        out_valid_q <= s4_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_q    <= s3_word_i;
      s4_pa_q <= pa_d;
    end
    if (out_en && s4_valid_q) begin
      out_q <= '{weight_out: w_new, velocity_out: s4_q.velocity};
    end
  end

  assign adv_o       = adv;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

[rtl/momentum_weight_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// momentum_weight_update
// SGD-with-momentum step engine: per-slot velocity EMA and weight update.
// ----------------------------------------------------------------------------
// Usage:
// - in channel: one word names a slot, a command (clear or update), the weight
//   and the gradient; out channel returns the new weight and the new velocity.
// - cfg channel: index 0 writes beta, index 1 the learning rate (Q0.16);
//   other indexes are ignored. Always ready; write only while the block is idle.
// - path: an accepted word passes s1, s2, s3, s4 and the output register in turn.
// - throughput: one word per cycle unless the output stalls. A word whose slot
//   matches the word in the first stage waits until that word moves on, as its
//   velocity is not yet written back; it is forwarded from write-back otherwise.
// - reset: registers return to their defaults and the velocity store is
//   zeroed by a sweep over all 1024 slots, during which in_ready_o stays low.
// - stall: results are held in the output register; the pipe keeps
//   accepting while it has an empty last stage, then holds with nothing lost.
// ----------------------------------------------------------------------------
module momentum_weight_update (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mwu_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mwu_pkg::out_word_t out_word_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  logic [15:0]        beta_q;
  logic [15:0]        alpha_q;
  logic               adv;
  logic               accept;
  logic               mem_busy;
  logic [31:0]        rd_data;
  mwu_pkg::slot_tag_t s1_tag;
  mwu_pkg::mem_wr_t   mem_wr;
  logic               s3_valid;
  mwu_pkg::vel_word_t s3_word;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q  <= mwu_pkg::MF_RESET;
      alpha_q <= mwu_pkg::LR_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mwu_pkg::CFG_MOMENTUM: beta_q  <= cfg_data_i;
        mwu_pkg::CFG_RATE:     alpha_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = adv && !mem_busy
                   && !(s1_tag.valid && (s1_tag.slot == in_word_i.slot_index));
  assign accept     = in_valid_i && in_ready_o;

  mwu_vel_mem u_vel_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (in_word_i.slot_index),
    .wr_i      (mem_wr),
    .rd_data_o (rd_data),
    .busy_o    (mem_busy)
  );

  mwu_vel_calc u_vel_calc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .accept_i   (accept),
    .in_word_i  (in_word_i),
    .rd_data_i  (rd_data),
    .beta_i     (beta_q),
    .s1_tag_o   (s1_tag),
    .mem_wr_o   (mem_wr),
    .s3_valid_o (s3_valid),
    .s3_word_o  (s3_word)
  );

  mwu_wgt_calc u_wgt_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s3_valid_i  (s3_valid),
    .s3_word_i   (s3_word),
    .alpha_i     (alpha_q),
    .out_ready_i (out_ready_i),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule
